[src/slrp_pkg.sv]
// Shared types, constants and helper functions for the quaternion slerp core.
package slrp_pkg;

  localparam int WQ = 30;
  localparam int TERMS = 10;
  localparam int QDEPTH = 2;
  localparam int QPW = $clog2(QDEPTH);
  localparam logic [30:0] HALF_PI_Q = 31'd1686629713;
  localparam logic [30:0] Q_ONE = 31'd1 << WQ;
  localparam logic [16:0] T_ONE = 17'd32768;

  typedef struct packed {
    logic [3:0][16:0] s;
    logic [3:0][15:0] e;
    logic [15:0]      tb;
    logic [30:0]      c;
    logic             linear;
  } slrp_item_t;

  typedef struct packed {
    logic        start;
    logic        odd;
    logic [30:0] x;
  } slrp_trig_req_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] sum;
  } slrp_trig_rsp_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SQ,
    T_MUL,
    T_RCP,
    T_COR
  } slrp_trig_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CAND,
    B_CWAIT,
    B_STH,
    B_STW,
    B_SAW,
    B_SBW,
    B_DIV,
    B_OUT
  } slrp_back_state_e;

  // series divisor (n+1)(n+2) for term k
  function automatic logic [8:0] term_div(input logic [3:0] k, input logic odd);
    logic [4:0] n;
    n = 5'({k, 1'b0}) - 5'd2 + 5'(odd);
    return 9'((n + 1) * (n + 2));
  endfunction

  // ceil(2^32 / divisor) for term k
  function automatic logic [31:0] term_recip(input logic [3:0] k, input logic odd);
    logic [31:0] r;
    case ({odd, k})
      5'h01:   r = 32'd2147483648;
      5'h02:   r = 32'd357913942;
      5'h03:   r = 32'd143165577;
      5'h04:   r = 32'd76695845;
      5'h05:   r = 32'd47721859;
      5'h06:   r = 32'd32537632;
      5'h07:   r = 32'd23598722;
      5'h08:   r = 32'd17895698;
      5'h09:   r = 32'd14035841;
      5'h0a:   r = 32'd11302546;
      5'h11:   r = 32'd715827883;
      5'h12:   r = 32'd214748365;
      5'h13:   r = 32'd102261127;
      5'h14:   r = 32'd59652324;
      5'h15:   r = 32'd39045158;
      5'h16:   r = 32'd27531842;
      5'h17:   r = 32'd20452226;
      5'h18:   r = 32'd15790321;
      5'h19:   r = 32'd12558384;
      5'h1a:   r = 32'd10226113;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [58:0] v);
    logic [15:0] r;
    if (v > 59'sd32767) begin
      r = 16'h7fff;
    end else if (v < -59'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp_sine(input logic signed [33:0] v);
    logic [31:0] r;
    if (v < 34'sd0) begin
      r = 32'd0;
    end else if (v > 34'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[src/quaternion_slerp_core.sv]
// Top level of the quaternion slerp core.
// A word is taken when start is high and busy is low; the front end classifies it in the
// same cycle and queues it (two words deep). Each word yields one result, shown for one
// cycle with done_o high; the receiver cannot stall. Near-parallel words (linear blend) go
// straight to the output blend in the back end. Slerp words are paced by the shared
// sine/cosine unit (up to 31 evaluations for the arccos bit search plus three sines) and
// the bit-serial weight divider.
module quaternion_slerp_core
  import slrp_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] start_x_i,
  input  logic signed [15:0] start_y_i,
  input  logic signed [15:0] start_z_i,
  input  logic signed [15:0] start_w_i,
  input  logic signed [15:0] end_x_i,
  input  logic signed [15:0] end_y_i,
  input  logic signed [15:0] end_z_i,
  input  logic signed [15:0] end_w_i,
  input  logic [15:0]        blend_i,
  output logic               done_o,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic signed [15:0] out_z_o,
  output logic signed [15:0] out_w_o,
  output logic               used_linear_o
);

  slrp_item_t       front_item;
  slrp_item_t       q_item;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             push;
  slrp_trig_req_t   trig_req;
  slrp_trig_rsp_t   trig_rsp;
  logic [3:0][15:0] comp;

  assign busy = q_full;
  assign push = start && !q_full;

  slrp_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .s_i    ({start_w_i, start_z_i, start_y_i, start_x_i}),
    .e_i    ({end_w_i, end_z_i, end_y_i, end_x_i}),
    .blend_i(blend_i),
    .item_o (front_item)
  );

  slrp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_item)
  );

  slrp_trig u_trig (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (trig_req),
    .rsp_o (trig_rsp)
  );

  slrp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .trig_req_o   (trig_req),
    .trig_rsp_i   (trig_rsp),
    .done_o       (done_o),
    .comp_o       (comp),
    .used_linear_o(used_linear_o)
  );

  assign out_x_o = comp[0];
  assign out_y_o = comp[1];
  assign out_z_o = comp[2];
  assign out_w_o = comp[3];

endmodule

[src/slrp_front.sv]
// Front end: dot product, hemisphere fold, near-parallel classification.
module slrp_front
  import slrp_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic [3:0][15:0] s_i,
  input  logic [3:0][15:0] e_i,
  input  logic [15:0]      blend_i,
  output slrp_item_t       item_o
);

  localparam logic [63:0] ONE = 64'd1 << (2 * FRAC_BITS);
  localparam logic [63:0] THR = ONE - ONE / 64'd2000;
  localparam int SH = 2 * FRAC_BITS - WQ;
  localparam int RSH = (SH >= 0) ? SH : 0;
  localparam int LSH = (SH < 0) ? -SH : 0;

  logic signed [31:0] prod [4];
  logic signed [33:0] dot;
  logic signed [33:0] dabs;
  logic               neg;
  logic [63:0]        cw;

  always_comb begin
    dot = '0;
    for (int i = 0; i < 4; i++) begin
      prod[i] = $signed(s_i[i]) * $signed(e_i[i]);
      dot = dot + 34'(prod[i]);
    end
  end

  assign neg  = dot[33];
  assign dabs = neg ? -dot : dot;
  assign cw   = (64'(dabs[32:0]) >> RSH) << LSH;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      item_o.s[i] = neg ? 17'(-$signed({s_i[i][15], s_i[i]})) : {s_i[i][15], s_i[i]};
      item_o.e[i] = e_i[i];
    end
    item_o.tb     = (blend_i > 16'd32768) ? 16'd32768 : blend_i;
    item_o.c      = (cw > 64'(Q_ONE)) ? Q_ONE : cw[30:0];
    item_o.linear = 64'(dabs[32:0]) >= THR;
  end

endmodule

[src/slrp_fifo.sv]
// Two-word queue between the front end and the back end.
module slrp_fifo
  import slrp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  slrp_item_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output slrp_item_t data_o
);

  slrp_item_t       mem_q [QDEPTH];
  logic [QPW-1:0]   wr_q;
  logic [QPW-1:0]   rd_q;
  logic [QPW:0]     cnt_q;

  assign full_o  = cnt_q == (QPW + 1)'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPW + 1)'(push_i) - (QPW + 1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("queue pop while empty");

endmodule

[src/slrp_trig.sv]
// Sequential Taylor-series sine/cosine unit, Q30 in and out.
module slrp_trig
  import slrp_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  slrp_trig_req_t req_i,
  output slrp_trig_rsp_t rsp_o
);

  slrp_trig_state_e   state_q, state_d;
  logic               odd_q;
  logic [30:0]        x_q;
  logic [31:0]        x2_q;
  logic [31:0]        term_q;
  logic [31:0]        p_q;
  logic [63:0]        prod_q;
  logic [3:0]         k_q;
  logic signed [33:0] sum_q;
  logic               done_q;

  logic [61:0]        sq;
  logic [8:0]         dv;
  logic [31:0]        qe;
  logic [31:0]        qc;
  logic [40:0]        qd;
  logic signed [33:0] sum_n;

  assign sq    = x_q * x_q;
  assign dv    = term_div(k_q, odd_q);
  assign qe    = prod_q[63:32];
  assign qd    = 41'(qe) * 41'(dv);
  assign qc    = (qd > 41'(p_q)) ? qe - 32'd1 : qe;
  assign sum_n = k_q[0] ? sum_q - $signed({2'b0, qc}) : sum_q + $signed({2'b0, qc});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: if (req_i.start) state_d = T_SQ;
      T_SQ:   state_d = T_MUL;
      T_MUL:  state_d = T_RCP;
      T_RCP:  state_d = T_COR;
      T_COR:  state_d = (k_q == 4'(TERMS)) ? T_IDLE : T_MUL;
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done = done_q;
    rsp_o.sum  = sum_q;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      T_IDLE: begin
        if (req_i.start) begin
          x_q   <= (req_i.x > HALF_PI_Q) ? HALF_PI_Q : req_i.x;
          odd_q <= req_i.odd;
        end
      end
      T_SQ: begin
        x2_q   <= sq[61:30];
        term_q <= odd_q ? 32'(x_q) : 32'(Q_ONE);
        sum_q  <= odd_q ? $signed(34'(x_q)) : $signed(34'(Q_ONE));
        k_q    <= 4'd1;
      end
      T_MUL: begin
        prod_q <= 64'(term_q) * 64'(x2_q);
      end
      T_RCP: begin
        p_q    <= prod_q[61:30];
        prod_q <= 64'(prod_q[61:30]) * 64'(term_recip(k_q, odd_q));
      end
      T_COR: begin
        term_q <= qc;
        sum_q  <= sum_n;
        k_q    <= k_q + 4'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == T_COR) && (k_q == 4'(TERMS));
    end
  end

endmodule

[src/slrp_back.sv]
// Back end: arccos search, weight sines, weight division and output blend.
module slrp_back
  import slrp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  slrp_item_t       item_i,
  output logic             item_pop_o,
  output slrp_trig_req_t   trig_req_o,
  input  slrp_trig_rsp_t   trig_rsp_i,
  output logic             done_o,
  output logic [3:0][15:0] comp_o,
  output logic             used_linear_o
);

  slrp_back_state_e state_q, state_d;
  slrp_item_t       it_q;
  logic             lin_q;
  logic [30:0]      lo_q;
  logic [4:0]       bit_q;
  logic [31:0]      sth_q;
  logic [31:0]      sa_q;
  logic [31:0]      sb_q;
  logic [39:0]      w0_q;
  logic [39:0]      w1_q;
  logic [61:0]      dnum_q;
  logic [31:0]      drem_q;
  logic [5:0]       dcnt_q;
  logic             dsel_q;
  logic [1:0]       idx_q;
  logic [3:0][15:0] outs_q;
  logic             ulin_q;
  logic             done_q;

  logic [31:0]        cand;
  logic               cand_ok;
  logic               cos_ge;
  logic [46:0]        xa_w;
  logic [46:0]        xb_w;
  logic [32:0]        rsh;
  logic               ge;
  logic [61:0]        quo;
  logic signed [16:0] sv;
  logic signed [15:0] ev;
  logic signed [58:0] vs;
  logic signed [58:0] vs_r;
  logic signed [35:0] vl;
  logic signed [35:0] vl_r;
  logic [15:0]        comp;

  assign cand    = 32'(lo_q) + (32'd1 << bit_q);
  assign cand_ok = cand <= 32'(HALF_PI_Q);
  assign cos_ge  = trig_rsp_i.sum >= $signed({3'b0, it_q.c});
  assign xa_w    = 47'(lo_q) * 47'(T_ONE - {1'b0, it_q.tb});
  assign xb_w    = 47'(lo_q) * 47'(it_q.tb);

  assign rsh = {drem_q, dnum_q[61]};
  assign ge  = rsh >= {1'b0, sth_q};
  assign quo = {dnum_q[60:0], ge};

  assign sv   = $signed(it_q.s[idx_q]);
  assign ev   = $signed(it_q.e[idx_q]);
  assign vs   = $signed({1'b0, w0_q}) * sv + $signed({1'b0, w1_q}) * ev;
  assign vs_r = (vs + 59'sd536870912) >>> WQ;
  assign vl   = $signed({1'b0, T_ONE - {1'b0, it_q.tb}}) * sv
              + $signed({2'b0, it_q.tb}) * ev;
  assign vl_r = (vl + 36'sd16384) >>> 15;
  assign comp = lin_q ? sat16(59'(vl_r)) : sat16(vs_r);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (item_valid_i) state_d = item_i.linear ? B_OUT : B_CAND;
      end
      B_CAND: begin
        if (cand_ok) begin
          state_d = B_CWAIT;
        end else if (bit_q == 5'd0) begin
          state_d = B_STH;
        end
      end
      B_CWAIT: begin
        if (trig_rsp_i.done) state_d = (bit_q == 5'd0) ? B_STH : B_CAND;
      end
      B_STH: state_d = B_STW;
      B_STW: begin
        if (trig_rsp_i.done) state_d = (trig_rsp_i.sum <= 34'sd0) ? B_OUT : B_SAW;
      end
      B_SAW: if (trig_rsp_i.done) state_d = B_SBW;
      B_SBW: if (trig_rsp_i.done) state_d = B_DIV;
      B_DIV: if (dcnt_q == 6'd61 && dsel_q) state_d = B_OUT;
      B_OUT: if (idx_q == 2'd3) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    item_pop_o       = 1'b0;
    trig_req_o.start = 1'b0;
    trig_req_o.odd   = 1'b1;
    trig_req_o.x     = lo_q;
    unique case (state_q)
      B_IDLE: item_pop_o = item_valid_i;
      B_CAND: begin
        trig_req_o.start = cand_ok;
        trig_req_o.odd   = 1'b0;
        trig_req_o.x     = cand[30:0];
      end
      B_STH: trig_req_o.start = 1'b1;
      B_STW: begin
        trig_req_o.start = trig_rsp_i.done && (trig_rsp_i.sum > 34'sd0);
        trig_req_o.x     = xa_w[45:15];
      end
      B_SAW: begin
        trig_req_o.start = trig_rsp_i.done;
        trig_req_o.x     = xb_w[45:15];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (item_valid_i) begin
          it_q  <= item_i;
          lin_q <= item_i.linear;
          lo_q  <= '0;
          bit_q <= 5'd30;
          idx_q <= '0;
        end
      end
      B_CAND: begin
        if (!cand_ok && bit_q != 5'd0) bit_q <= bit_q - 5'd1;
      end
      B_CWAIT: begin
        if (trig_rsp_i.done) begin
          if (cos_ge) lo_q <= cand[30:0];
          if (bit_q != 5'd0) bit_q <= bit_q - 5'd1;
        end
      end
      B_STW: begin
        if (trig_rsp_i.done) begin
          sth_q <= trig_rsp_i.sum[31:0];
          if (trig_rsp_i.sum <= 34'sd0) lin_q <= 1'b1;
        end
      end
      B_SAW: begin
        if (trig_rsp_i.done) sa_q <= clamp_sine(trig_rsp_i.sum);
      end
      B_SBW: begin
        if (trig_rsp_i.done) begin
          sb_q   <= clamp_sine(trig_rsp_i.sum);
          dnum_q <= {sa_q, 30'b0};
          drem_q <= '0;
          dcnt_q <= '0;
          dsel_q <= 1'b0;
        end
      end
      B_DIV: begin
        drem_q <= ge ? 32'(rsh - {1'b0, sth_q}) : rsh[31:0];
        dnum_q <= quo;
        dcnt_q <= dcnt_q + 6'd1;
        if (dcnt_q == 6'd61) begin
          if (!dsel_q) begin
            w0_q   <= quo[39:0];
            dnum_q <= {sb_q, 30'b0};
            drem_q <= '0;
            dcnt_q <= '0;
            dsel_q <= 1'b1;
          end else begin
            w1_q <= quo[39:0];
          end
        end
      end
      B_OUT: begin
        outs_q[idx_q] <= comp;
        idx_q         <= idx_q + 2'd1;
        if (idx_q == 2'd3) ulin_q <= lin_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == B_OUT) && (idx_q == 2'd3);
    end
  end

  assign done_o        = done_q;
  assign comp_o        = outs_q;
  assign used_linear_o = ulin_q;

  a_done_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == B_OUT)
    else $error("result word without output pass");
  a_trig_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_rsp_i.done |-> (state_q == B_CWAIT || state_q == B_STW ||
                         state_q == B_SAW || state_q == B_SBW))
    else $error("trig result arrived outside a wait state");

endmodule

[tb/quaternion_slerp_core_tb.sv]
// Self-checking testbench for quaternion_slerp_core: random and directed slerp words.
`timescale 1ns / 100ps

module quaternion_slerp_core_tb;
  import slrp_pkg::*;

  typedef struct {
    logic signed [15:0] s[4];
    logic signed [15:0] e[4];
    logic [15:0]        blend;
  } quat_word_t;

  typedef struct {
    logic signed [15:0] q[4];
    logic               lin;
  } quat_res_t;

  class slerp_scoreboard;
    quat_res_t pending[$];
    int        errors = 0;

    function longint trig_series(longint x, bit odd);
      longint unsigned ux, x2, term, n;
      longint sum;
      if (x < 0) x = 0;
      if (x > longint'(HALF_PI_Q)) x = longint'(HALF_PI_Q);
      ux = x;
      x2 = (ux * ux) >> 30;
      term = odd ? ux : (64'd1 << 30);
      n = odd ? 1 : 0;
      sum = term;
      for (int k = 1; k <= 10; k++) begin
        term = ((term * x2) >> 30) / ((n + 1) * (n + 2));
        n += 2;
        if (k & 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      return sum;
    endfunction

    function longint arccos_search(longint c);
      longint lo, cand;
      lo = 0;
      for (int b = 30; b >= 0; b--) begin
        cand = lo + (longint'(1) << b);
        if (cand <= longint'(HALF_PI_Q) && trig_series(cand, 0) >= c) lo = cand;
      end
      return lo;
    endfunction

    function longint sine_clip(longint v);
      if (v < 0) v = 0;
      if (v > (longint'(1) << 31)) v = longint'(1) << 31;
      return v;
    endfunction

    function longint round_sh(longint v, int sh);
      longint unsigned u;
      u = longint'(v) + (64'd1 << (sh - 1)) + (64'd1 << 62);
      return longint'(u >> sh) - longint'((64'd1 << 62) >> sh);
    endfunction

    function logic signed [15:0] sat_q(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function quat_res_t slerp_predict(quat_word_t w);
      longint s[4], e[4];
      longint dot, tb, c, th, sth, sa, sb, w0, w1;
      quat_res_t r;
      bit lin;
      dot = 0;
      for (int i = 0; i < 4; i++) begin
        s[i] = w.s[i];
        e[i] = w.e[i];
        dot += s[i] * e[i];
      end
      tb = w.blend;
      if (tb > 32768) tb = 32768;
      if (dot < 0) begin
        dot = -dot;
        for (int i = 0; i < 4; i++) s[i] = -s[i];
      end
      lin = dot >= (longint'(1) << 28) - (longint'(1) << 28) / 2000;
      if (!lin) begin
        c = dot <<< 2;
        if (c > (longint'(1) << 30)) c = longint'(1) << 30;
        th = arccos_search(c);
        sth = trig_series(th, 1);
        if (sth <= 0) begin
          lin = 1;
        end else begin
          sa = sine_clip(trig_series((th * (32768 - tb)) >>> 15, 1));
          sb = sine_clip(trig_series((th * tb) >>> 15, 1));
          w0 = (sa << 30) / sth;
          w1 = (sb << 30) / sth;
          for (int i = 0; i < 4; i++) r.q[i] = sat_q(round_sh(w0 * s[i] + w1 * e[i], 30));
          r.lin = 0;
        end
      end
      if (lin) begin
        for (int i = 0; i < 4; i++)
          r.q[i] = sat_q(round_sh((32768 - tb) * s[i] + tb * e[i], 15));
        r.lin = 1;
      end
      return r;
    endfunction

    function void note_word(quat_word_t w);
      pending.push_back(slerp_predict(w));
    endfunction

    function void check_result(quat_res_t a);
      quat_res_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %0d %0d %0d %0d lin=%0d", $time,
                 a.q[0], a.q[1], a.q[2], a.q[3], a.lin);
        errors++;
        return;
      end
      x = pending.pop_front();
      for (int i = 0; i < 4; i++)
        if (x.q[i] !== a.q[i]) begin
          $display("%0t: out[%0d] expected %0d actual %0d", $time, i, x.q[i], a.q[i]);
          errors++;
        end
      if (x.lin !== a.lin) begin
        $display("%0t: used_linear expected %0d actual %0d", $time, x.lin, a.lin);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [15:0] sx = 0, sy = 0, sz = 0, sw = 0, ex = 0, ey = 0, ez = 0, ew = 0;
  logic [15:0] blend = 0;
  logic done;
  logic signed [15:0] ox, oy, oz, ow;
  logic used_lin;

  slerp_scoreboard sb = new();
  int idle_pct = 0;
  longint cycles = 0;

  quaternion_slerp_core i_dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .start_x_i(sx), .start_y_i(sy), .start_z_i(sz), .start_w_i(sw),
    .end_x_i(ex), .end_y_i(ey), .end_z_i(ez), .end_w_i(ew), .blend_i(blend),
    .done_o(done), .out_x_o(ox), .out_y_o(oy), .out_z_o(oz), .out_w_o(ow),
    .used_linear_o(used_lin)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    quat_res_t r;
    cycles <= cycles + 1;
    if (cycles > 5000000) begin
      $display("** quaternion_slerp_core: FAILED **");
      $finish;
    end
    if (done) begin
      r.q[0] = ox; r.q[1] = oy; r.q[2] = oz; r.q[3] = ow; r.lin = used_lin;
      sb.check_result(r);
    end
  end

  task automatic send_word(quat_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    {sx, sy, sz, sw} <= {w.s[0], w.s[1], w.s[2], w.s[3]};
    {ex, ey, ez, ew} <= {w.e[0], w.e[1], w.e[2], w.e[3]};
    blend <= w.blend;
    do @(posedge clk); while (busy);
    sb.note_word(w);
  endtask

  task automatic drain();
    start <= 0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  function automatic quat_word_t mk(int a0, a1, a2, a3, b0, b1, b2, b3, int t);
    quat_word_t w;
    w.s[0] = 16'(a0); w.s[1] = 16'(a1); w.s[2] = 16'(a2); w.s[3] = 16'(a3);
    w.e[0] = 16'(b0); w.e[1] = 16'(b1); w.e[2] = 16'(b2); w.e[3] = 16'(b3);
    w.blend = 16'(t);
    return w;
  endfunction

  function automatic quat_word_t rand_word();
    quat_word_t w;
    int kind, d;
    kind = $urandom_range(99);
    w.blend = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
    for (int i = 0; i < 4; i++) begin
      if (kind < 20) begin
        w.s[i] = 16'($urandom);
        w.e[i] = 16'($urandom);
      end else begin
        w.s[i] = $signed(16'($urandom_range(16384))) - 16'sd8192;
        if (kind < 60) begin
          w.e[i] = $signed(16'($urandom_range(16384))) - 16'sd8192;
        end else begin
          d = $urandom_range(600) - 300;
          w.e[i] = ($urandom_range(1)) ? 16'(w.s[i] + d) : 16'(-(w.s[i] + d));
        end
      end
    end
    if (kind >= 20 && kind < 40) begin
      w.s[$urandom_range(3)] = 16'sd16384;
    end
    return w;
  endfunction

  initial begin
    quat_word_t dl[$];
    dl.push_back(mk(0, 0, 0, 16384, 0, 0, 0, 16384, 0));
    dl.push_back(mk(0, 0, 0, 16384, 16384, 0, 0, 0, 0));
    dl.push_back(mk(0, 0, 0, 16384, 16384, 0, 0, 0, 32768));
    dl.push_back(mk(0, 0, 0, 16384, 16384, 0, 0, 0, 16384));
    dl.push_back(mk(0, 0, 0, 16384, 16384, 0, 0, 0, 65535));
    dl.push_back(mk(0, 0, 0, 16384, 0, 0, 11585, 11585, 12345));
    dl.push_back(mk(0, 0, 0, 16384, 0, 0, 0, -16384, 16384));
    dl.push_back(mk(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 20000));
    dl.push_back(mk(-32768, 0, 0, 0, 16384, 0, 0, 0, 1));
    dl.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    dl.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 5000));
    dl.push_back(mk(100, -200, 300, 16380, 110, -190, 290, 16381, 9000));
    dl.push_back(mk(0, 0, 0, 16384, 0, 0, 520, 16376, 30000));
    dl.push_back(mk(0, 0, 0, 16384, 0, 0, 500, 16377, 40000));
    dl.push_back(mk(8192, 8192, 8192, 8192, -8192, 8192, -8192, 8192, 32768));
    dl.push_back(mk(-1, 1, -1, 1, 1, -1, 1, -1, 16384));
    dl.push_back(mk(16384, 0, 0, 0, -16383, 0, 181, 0, 24576));
    rst_n <= 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (dl[i]) send_word(dl[i]);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 30 : (ph == 1) ? 88 : 0;
      for (int n = 0; n < 265; n++) begin
        if (n == 130) drain();
        send_word(rand_word());
      end
    end
    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** quaternion_slerp_core: PASSED **");
    end else begin
      $display("** quaternion_slerp_core: FAILED **");
    end
    $finish;
  end

endmodule
